// ===== rtl/swm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  localparam int unsigned WINDOW = 7;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned IDX_W  = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);

  typedef logic [DATA_W-1:0] sample_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    logic load;
    logic step;
    logic push;
  } swm_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } swm_sts_t;

endpackage

`default_nettype wire

// ===== rtl/swm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire swm_pkg::swm_sts_t sts_i,
  output swm_pkg::swm_cmd_t      cmd_o
);
  import swm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_PUSH = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swm_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swm_dpath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire swm_pkg::sample_t  sample_i,
  input  wire swm_pkg::swm_cmd_t cmd_i,
  output swm_pkg::swm_sts_t      sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output swm_pkg::sample_t       out_data_o
);
  import swm_pkg::*;

  sample_t store_q [WINDOW];
  idx_t    wslot_q;
  cnt_t    fill_q;
  idx_t    cand_q;
  sample_t sel_q;
  sample_t out_data_q;
  logic    out_valid_q;

  sample_t cand_val;
  logic    cand_ok;
  cnt_t    rank;
  cnt_t    target;
  logic    last;

  // rank of candidate = entries strictly below it, ties broken by index
  always_comb begin
    cand_val = store_q[cand_q];
    cand_ok  = {1'b0, cand_q} < {1'b0, fill_q};
    rank     = '0;
    for (int unsigned j = 0; j < WINDOW; j++) begin
      if (CNT_W'(j) < fill_q) begin
        if ((store_q[j] < cand_val) ||
            ((store_q[j] == cand_val) && (IDX_W'(j) < cand_q))) begin
          rank = rank + CNT_W'(1);
        end
      end
    end
    target = (fill_q - CNT_W'(1)) - (fill_q >> 1);
    last   = cand_q == IDX_W'(WINDOW - 1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      store_q[wslot_q] <= sample_i;
    end
    if (cmd_i.step && cand_ok && (rank == target)) begin
      sel_q <= cand_val;
    end
    if (cmd_i.push) begin
      out_data_q <= sel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q     <= '0;
      fill_q      <= '0;
      cand_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        wslot_q <= (wslot_q == IDX_W'(WINDOW - 1)) ? '0 : wslot_q + IDX_W'(1);
        if (fill_q != CNT_W'(WINDOW)) begin
          fill_q <= fill_q + CNT_W'(1);
        end
        cand_q <= '0;
      end else if (cmd_i.step) begin
        cand_q <= last ? '0 : cand_q + IDX_W'(1);
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.scan_last = last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_median_top.sv =====
// Running median over the last WINDOW (7) samples.
// Flow: ST_IDLE stores the sample, ST_SCAN ranks the window entries, one entry per
// cycle, and ST_PUSH loads the median into the result register, waiting while it
// is full and not read; a new sample is taken only after the last median is pushed.
// Reset (async, active low) empties the window and clears all handshake state.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // [15:0] sample
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [15:0] m_axis_tdata_o   // [15:0] median
);
  import swm_pkg::*;

  swm_cmd_t cmd;
  swm_sts_t sts;
  sample_t  med;

  swm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swm_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (med)
  );

  assign m_axis_tdata_o = med;

endmodule

`default_nettype wire
